// ===== src/cnls_pkg.sv =====
// shared types, constants and step tables for the character lcd nibble sequencer
// no dependencies; imported by the front, queue and back modules

package cnls_pkg;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned WAIT_W     = 14;

  localparam logic [3:0]        STEP_LAST   = 4'd11;
  localparam logic [WAIT_W-1:0] BYTE_EXTRA  = 14'd40;
  localparam logic [WAIT_W-1:0] CLEAR_EXTRA = 14'd2000;

  localparam logic [1:0] OPC_INIT  = 2'd0;
  localparam logic [1:0] OPC_PUT   = 2'd1;
  localparam logic [1:0] OPC_CLEAR = 2'd2;
  localparam logic [1:0] OPC_GOTO  = 2'd3;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] ROW1_OFFSET  = 8'h40;

  // function set, display on, entry mode, clear
  localparam logic [7:0] INIT_BYTES [4] = '{8'h28, 8'h0D, 8'h06, 8'h01};

  typedef enum logic [1:0] {
    OP_RS   = 2'd0,
    OP_EN   = 2'd1,
    OP_DATA = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [1:0]        pos;
    logic              val;
    logic [WAIT_W-1:0] extra;
  } micro_op_t;

  // one decoded command as it sits in the queue
  typedef struct packed {
    logic       is_init;
    logic       is_clr;
    logic       rs;
    logic [7:0] data;
  } cmd_entry_t;

  function automatic micro_op_t mk_op(op_kind_t kind, logic [1:0] pos, logic val,
                                      logic [WAIT_W-1:0] extra);
    micro_op_t op;
    op.kind  = kind;
    op.pos   = pos;
    op.val   = val;
    op.extra = extra;
    return op;
  endfunction

  // power-on wake-up sequence before the init bytes
  function automatic micro_op_t init_step(logic [3:0] sub);
    micro_op_t op;
    op = mk_op(OP_EN, 2'd0, 1'b0, '0);
    unique case (sub)
      4'd0:    op = mk_op(OP_RS, 2'd0, 1'b0, 14'd15000);
      4'd1:    op = mk_op(OP_DATA, 2'd0, 1'b1, '0);
      4'd2:    op = mk_op(OP_DATA, 2'd1, 1'b1, '0);
      4'd3:    op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd4:    op = mk_op(OP_EN, 2'd0, 1'b0, 14'd5000);
      4'd5:    op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd6:    op = mk_op(OP_EN, 2'd0, 1'b0, 14'd100);
      4'd7:    op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd8:    op = mk_op(OP_EN, 2'd0, 1'b0, 14'd5000);
      4'd9:    op = mk_op(OP_DATA, 2'd0, 1'b0, '0);
      4'd10:   op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd11:   op = mk_op(OP_EN, 2'd0, 1'b0, BYTE_EXTRA);
      default: op = mk_op(OP_EN, 2'd0, 1'b0, '0);
    endcase
    return op;
  endfunction

  // high nibble d7..d4, strobe, low nibble, strobe
  function automatic micro_op_t byte_step(logic [3:0] sub, logic [7:0] b);
    micro_op_t op;
    op = mk_op(OP_EN, 2'd0, 1'b0, '0);
    unique case (sub)
      4'd0:    op = mk_op(OP_DATA, 2'd3, b[7], '0);
      4'd1:    op = mk_op(OP_DATA, 2'd2, b[6], '0);
      4'd2:    op = mk_op(OP_DATA, 2'd1, b[5], '0);
      4'd3:    op = mk_op(OP_DATA, 2'd0, b[4], '0);
      4'd4:    op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd5:    op = mk_op(OP_EN, 2'd0, 1'b0, '0);
      4'd6:    op = mk_op(OP_DATA, 2'd3, b[3], '0);
      4'd7:    op = mk_op(OP_DATA, 2'd2, b[2], '0);
      4'd8:    op = mk_op(OP_DATA, 2'd1, b[1], '0);
      4'd9:    op = mk_op(OP_DATA, 2'd0, b[0], '0);
      4'd10:   op = mk_op(OP_EN, 2'd0, 1'b1, '0);
      4'd11:   op = mk_op(OP_EN, 2'd0, 1'b0, BYTE_EXTRA);
      default: op = mk_op(OP_EN, 2'd0, 1'b0, '0);
    endcase
    return op;
  endfunction

endpackage

// ===== src/char_lcd_nibble_sequencer_core.sv =====
// first pin change: an accepted command is registered in the queue, and its first pin
// change then goes into the output register; one pin change per cycle from the back
// sequencer while the output is not stalled; a two-entry queue lets commands be taken
// while the previous one is still being sequenced
// reset: synchronous, clears queue, sequencer and pin levels; pin settle time 10 us
// depends on cnls_pkg, cnls_front, cnls_queue, cnls_back

module char_lcd_nibble_sequencer_core #(
  parameter int unsigned LINE_WIDTH = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // opcode[1:0]
  input  logic [1:0]                         s_tuser,
  // char_code[7:0], column[13:8], row[15:14]
  input  logic [cnls_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // reg_select[0], enable_pin[1], data_nibble[5:2], wait_us[19:6], zero pad
  output logic [cnls_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_data
);
  import cnls_pkg::*;

  logic [7:0]        pin_settle_us;
  cmd_entry_t        dec_entry;
  cmd_entry_t        head;
  logic              q_not_full;
  logic              q_not_empty;
  logic              q_pop;
  logic              reg_select;
  logic              enable_pin;
  logic [3:0]        data_nibble;
  logic [WAIT_W-1:0] wait_us;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_settle_us <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      pin_settle_us <= cfg_data;
    end
  end

  cnls_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .opcode    (s_tuser),
    .char_code (s_tdata[7:0]),
    .column    (s_tdata[13:8]),
    .row       (s_tdata[15:14]),
    .entry     (dec_entry)
  );

  assign s_tready = q_not_full;

  cnls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_entry (dec_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  cnls_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_entry     (head),
    .q_pop       (q_pop),
    .settle      (pin_settle_us),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .reg_select  (reg_select),
    .enable_pin  (enable_pin),
    .data_nibble (data_nibble),
    .wait_us     (wait_us),
    .last        (m_tlast)
  );

  assign m_tdata = {4'd0, wait_us, data_nibble, enable_pin, reg_select};

endmodule

// ===== src/cnls_front.sv =====
// command decoder: turns an incoming command into a queue entry
// depends on cnls_pkg

module cnls_front #(
  parameter int unsigned LINE_WIDTH = 20
) (
  input  logic [1:0]          opcode,
  input  logic [7:0]          char_code,
  input  logic [5:0]          column,
  input  logic [1:0]          row,
  output cnls_pkg::cmd_entry_t entry
);
  import cnls_pkg::*;

  localparam logic [7:0] LW = 8'(LINE_WIDTH);

  logic [7:0] offset;

  always_comb begin
    unique case (row)
      2'd0:    offset = 8'd0;
      2'd1:    offset = ROW1_OFFSET;
      2'd2:    offset = LW;
      default: offset = ROW1_OFFSET + LW;
    endcase
  end

  always_comb begin
    entry.is_init = (opcode == OPC_INIT);
    entry.is_clr  = (opcode == OPC_CLEAR);
    entry.rs      = (opcode == OPC_PUT);
    unique case (opcode)
      OPC_PUT:   entry.data = char_code;
      OPC_CLEAR: entry.data = CMD_CLEAR;
      OPC_GOTO:  entry.data = CMD_SET_ADDR + {2'b00, column} + offset;
      default:   entry.data = CMD_CLEAR;
    endcase
  end

endmodule

// ===== src/cnls_queue.sv =====
// two-entry command queue between decoder and pin sequencer
// depends on cnls_pkg

module cnls_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cnls_pkg::cmd_entry_t push_entry,
  output logic                 not_full,
  input  logic                 pop,
  output logic                 not_empty,
  output cnls_pkg::cmd_entry_t head
);
  import cnls_pkg::*;

  cmd_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_full  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && not_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && not_full, pop && not_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/cnls_back.sv =====
// pin sequencer: steps through the pin changes of the queue head, one per cycle while the
// output is not stalled, into the output register; depends on cnls_pkg

module cnls_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  cnls_pkg::cmd_entry_t          q_entry,
  output logic                          q_pop,
  input  logic [7:0]                    settle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          reg_select,
  output logic                          enable_pin,
  output logic [3:0]                    data_nibble,
  output logic [cnls_pkg::WAIT_W-1:0]   wait_us,
  output logic                          last
);
  import cnls_pkg::*;

  typedef enum logic [1:0] {
    ST_PRE  = 2'b01,
    ST_BYTE = 2'b10
  } seq_state_t;

  seq_state_t state;
  logic [3:0] sub;
  logic [1:0] byte_num;

  logic       advance;
  logic       fire;
  logic       last_byte;
  logic       final_step;
  logic [3:0] pre_last;
  logic [7:0] cur_byte;
  micro_op_t  op;

  assign advance = !out_valid || out_ready;
  assign fire    = q_valid && advance;

  always_comb begin
    pre_last   = q_entry.is_init ? STEP_LAST : 4'd0;
    last_byte  = q_entry.is_init ? (byte_num == 2'd3) : 1'b1;
    cur_byte   = q_entry.is_init ? INIT_BYTES[byte_num] : q_entry.data;
    final_step = (state == ST_BYTE) && (sub == STEP_LAST) && last_byte;
    if (state == ST_PRE) begin
      op = q_entry.is_init ? init_step(sub) : mk_op(OP_RS, 2'd0, q_entry.rs, '0);
    end else begin
      op = byte_step(sub, cur_byte);
      if (final_step && q_entry.is_clr) begin
        op.extra = op.extra + CLEAR_EXTRA;
      end
    end
  end

  assign q_pop = fire && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_PRE;
      sub      <= 4'd0;
      byte_num <= 2'd0;
    end else if (fire) begin
      unique case (state)
        ST_PRE: begin
          if (sub == pre_last) begin
            state    <= ST_BYTE;
            sub      <= 4'd0;
            byte_num <= 2'd0;
          end else begin
            sub <= sub + 4'd1;
          end
        end
        ST_BYTE: begin
          if (sub == STEP_LAST) begin
            sub <= 4'd0;
            if (last_byte) begin
              state    <= ST_PRE;
              byte_num <= 2'd0;
            end else begin
              byte_num <= byte_num + 2'd1;
            end
          end else begin
            sub <= sub + 4'd1;
          end
        end
        default: begin
          state <= ST_PRE;
          sub   <= 4'd0;
        end
      endcase
    end
  end

  // pin levels live in the output register and persist across commands
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      reg_select  <= 1'b0;
      enable_pin  <= 1'b0;
      data_nibble <= 4'd0;
    end else if (advance) begin
      out_valid <= fire;
      if (fire) begin
        unique case (op.kind)
          OP_RS:   reg_select        <= op.val;
          OP_EN:   enable_pin        <= op.val;
          OP_DATA: data_nibble[op.pos] <= op.val;
          default: enable_pin        <= enable_pin;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      wait_us <= WAIT_W'(settle) + op.extra;
      last    <= final_step;
    end
  end

endmodule

// ===== src/cnls_checker.sv =====
// port-level checks for the sequencer core, bound onto the top level
// depends on cnls_pkg and char_lcd_nibble_sequencer_core

module cnls_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cnls_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // every command ends on a strobe falling edge
  a_last_en_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[1])
    else $error("final pin change leaves enable high");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:20] == 4'd0)
    else $error("padding bits set");

endmodule

bind char_lcd_nibble_sequencer_core cnls_checker u_cnls_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast)
);

// ===== tb/cnls_lcd_checker.sv =====
`timescale 1ns / 100ps
// checker for the character lcd nibble sequencer: watches the command, pin and settle channels,
// predicts every pin change and compares it with what the block sends; depends on cnls_pkg

module cnls_lcd_checker #(
  parameter int unsigned LINE_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [1:0]                      s_tuser,
  input  logic [cnls_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [cnls_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [7:0]                      cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  localparam logic [7:0]  SETTLE_RESET = 8'd10;
  localparam logic [13:0] WAKE_HOLD    = 14'd15000;
  localparam logic [13:0] RESET_HOLD   = 14'd5000;
  localparam logic [13:0] SHORT_HOLD   = 14'd100;
  localparam logic [13:0] BYTE_HOLD    = 14'd40;
  localparam logic [13:0] CLEAR_HOLD   = 14'd2000;
  localparam int          MAX_CHANGES  = 60;
  localparam int          REPORT_CAP   = 20;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [13:0] wait_us;
    logic        last;
  } pin_change_t;

  // pin levels as the display sees them, and the current settle time
  logic [7:0]  settle_us;
  logic        lcd_rs;
  logic        lcd_en;
  logic [3:0]  lcd_nib;

  pin_change_t cmd_changes [MAX_CHANGES];
  int          cmd_len;
  pin_change_t expected_changes [$];
  int          err_n;
  int          checked_n;

  task automatic note_change();
    pin_change_t c;
    c.rs      = lcd_rs;
    c.en      = lcd_en;
    c.nib     = lcd_nib;
    c.wait_us = {6'd0, settle_us};
    c.last    = 1'b0;
    cmd_changes[cmd_len] = c;
    cmd_len++;
  endtask

  task automatic hold_extra(input logic [13:0] extra);
    pin_change_t c;
    c = cmd_changes[cmd_len-1];
    c.wait_us = c.wait_us + extra;
    cmd_changes[cmd_len-1] = c;
  endtask

  task automatic set_rs(input logic v);
    lcd_rs = v;
    note_change();
  endtask

  task automatic set_en(input logic v);
    lcd_en = v;
    note_change();
  endtask

  task automatic set_d(input int pos, input logic v);
    lcd_nib[pos] = v;
    note_change();
  endtask

  task automatic pulse_enable();
    set_en(1'b1);
    set_en(1'b0);
  endtask

  // high nibble first, one pin at a time, each nibble latched by a strobe
  task automatic write_lcd_byte(input logic [7:0] b);
    for (int i = 7; i >= 4; i--) set_d(i - 4, b[i]);
    pulse_enable();
    for (int i = 3; i >= 0; i--) set_d(i, b[i]);
    pulse_enable();
    hold_extra(BYTE_HOLD);
  endtask

  task automatic predict_command(input logic [1:0] opc,
                                 input logic [cnls_pkg::IN_DATA_W-1:0] d);
    logic [7:0]  ch;
    logic [5:0]  col;
    logic [1:0]  row;
    logic [7:0]  offset;
    pin_change_t c;
    ch  = d[7:0];
    col = d[13:8];
    row = d[15:14];
    cmd_len = 0;
    case (opc)
      cnls_pkg::OPC_INIT: begin
        set_rs(1'b0);
        hold_extra(WAKE_HOLD);
        set_d(0, 1'b1);
        set_d(1, 1'b1);
        pulse_enable();
        hold_extra(RESET_HOLD);
        pulse_enable();
        hold_extra(SHORT_HOLD);
        pulse_enable();
        hold_extra(RESET_HOLD);
        set_d(0, 1'b0);
        pulse_enable();
        hold_extra(BYTE_HOLD);
        for (int k = 0; k < 4; k++) write_lcd_byte(cnls_pkg::INIT_BYTES[k]);
      end
      cnls_pkg::OPC_PUT: begin
        set_rs(1'b1);
        write_lcd_byte(ch);
      end
      cnls_pkg::OPC_CLEAR: begin
        set_rs(1'b0);
        write_lcd_byte(cnls_pkg::CMD_CLEAR);
        hold_extra(CLEAR_HOLD);
      end
      default: begin
        case (row)
          2'd0:    offset = 8'd0;
          2'd1:    offset = cnls_pkg::ROW1_OFFSET;
          2'd2:    offset = 8'(LINE_WIDTH);
          default: offset = cnls_pkg::ROW1_OFFSET + 8'(LINE_WIDTH);
        endcase
        set_rs(1'b0);
        // no range check on the column, the address just wraps
        write_lcd_byte(cnls_pkg::CMD_SET_ADDR + {2'b00, col} + offset);
      end
    endcase
    c = cmd_changes[cmd_len-1];
    c.last = 1'b1;
    cmd_changes[cmd_len-1] = c;
    for (int k = 0; k < cmd_len; k++) expected_changes.push_back(cmd_changes[k]);
  endtask

  always @(posedge clk) begin
    pin_change_t got;
    pin_change_t want;
    if (rst) begin
      settle_us = SETTLE_RESET;
      lcd_rs    = 1'b0;
      lcd_en    = 1'b0;
      lcd_nib   = 4'd0;
      expected_changes.delete();
      err_n     = 0;
      checked_n = 0;
    end else begin
      if (cfg_valid && cfg_ready) settle_us = cfg_data;
      if (s_tvalid && s_tready) predict_command(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.rs      = m_tdata[0];
        got.en      = m_tdata[1];
        got.nib     = m_tdata[5:2];
        got.wait_us = m_tdata[19:6];
        got.last    = m_tlast;
        if (expected_changes.size() == 0) begin
          err_n++;
          if (err_n <= REPORT_CAP)
            $display("%0t: pin change with nothing expected: %s rs=%0d en=%0d d=%h",
                     $time, "got", got.rs, got.en, got.nib,
                     " wait=%0d last=%0d", got.wait_us, got.last);
        end else begin
          want = expected_changes.pop_front();
          checked_n++;
          if (got !== want) begin
            err_n++;
            if (err_n <= REPORT_CAP) begin
              $display("%0t: pin change %0d: expected rs=%0d en=%0d d=%h wait=%0d last=%0d",
                       $time, checked_n, want.rs, want.en, want.nib, want.wait_us,
                       want.last);
              $display("%0t: pin change %0d: got      rs=%0d en=%0d d=%h wait=%0d last=%0d",
                       $time, checked_n, got.rs, got.en, got.nib, got.wait_us, got.last);
            end
          end
        end
      end
    end
    fail_count <= err_n;
    pending    <= expected_changes.size();
    checked    <= checked_n;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// top of the testbench for char_lcd_nibble_sequencer_core: clock, reset, command and settle
// stimulus, output backpressure and the verdict; depends on cnls_pkg and cnls_lcd_checker

module tb;

  localparam int unsigned LINE_WIDTH  = 20;
  localparam int          CYCLE_LIMIT = 1500000;
  localparam int          NUM_PHASES  = 6;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [1:0]                      s_tuser   = 2'd0;
  logic [cnls_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [cnls_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [7:0]                      cfg_data  = 8'd0;

  int fail_count;
  int pending;
  int checked;

  int cycle_count = 0;
  int rx_mode     = 0;
  int rx_hold     = 0;
  bit rx_level    = 1'b0;
  int gap_max     = 0;
  int burst_left  = 0;
  int n_settings  = 1;
  int n_cmd [4]   = '{0, 0, 0, 0};

  // settle value per phase, -1 picks one at random
  int ph_settle [NUM_PHASES] = '{0, 255, -1, -1, 1, -1};
  int ph_rx     [NUM_PHASES] = '{2, 1, 0, 2, 1, 2};
  int ph_gap    [NUM_PHASES] = '{6, 12, 0, 15, 3, 8};
  int ph_items  [NUM_PHASES] = '{80, 80, 70, 80, 70, 70};

  char_lcd_nibble_sequencer_core #(
    .LINE_WIDTH(LINE_WIDTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  cnls_lcd_checker #(
    .LINE_WIDTH(LINE_WIDTH)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: gave up after %0d cycles with %0d pin changes outstanding",
               cycle_count, pending);
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: always ready, coin toss per cycle, or alternating ready and stall runs
  always @(posedge clk) begin
    if (rx_mode == 0) begin
      m_tready <= 1'b1;
    end else if (rx_mode == 1) begin
      m_tready <= 1'($urandom_range(0, 1));
    end else begin
      if (rx_hold == 0) begin
        rx_level = !rx_level;
        rx_hold  = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 12);
      end else begin
        rx_hold--;
      end
      m_tready <= rx_level;
    end
  end

  // idle gap at the end of each burst
  task automatic pace();
    if (gap_max > 0) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch, input logic [5:0] col,
                          input logic [1:0] row);
    logic [cnls_pkg::IN_DATA_W-1:0] w;
    w        = '0;
    w[7:0]   = ch;
    w[13:8]  = col;
    w[15:14] = row;
    s_tuser  <= op;
    s_tdata  <= w;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    n_cmd[op]++;
    pace();
  endtask

  task automatic send_random();
    int         pick;
    logic [1:0] op;
    logic [5:0] col;
    pick = $urandom_range(0, 99);
    if (pick < 5)       op = cnls_pkg::OPC_INIT;
    else if (pick < 60) op = cnls_pkg::OPC_PUT;
    else if (pick < 75) op = cnls_pkg::OPC_CLEAR;
    else                op = cnls_pkg::OPC_GOTO;
    // mostly on-screen columns, some past the end of the line
    col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63)) : 6'($urandom_range(0, 39));
    send_cmd(op, 8'($urandom_range(0, 255)), col, 2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_settle(input logic [7:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int sv;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ignored fields set, byte extremes, every row, line overrun and address wrap
    send_cmd(cnls_pkg::OPC_INIT,  8'hFF, 6'd63, 2'd3);
    send_cmd(cnls_pkg::OPC_PUT,   8'h00, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_PUT,   8'hFF, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_PUT,   8'hA5, 6'd42, 2'd2);
    send_cmd(cnls_pkg::OPC_PUT,   8'h5A, 6'd21, 2'd1);
    send_cmd(cnls_pkg::OPC_CLEAR, 8'hFF, 6'd63, 2'd3);
    send_cmd(cnls_pkg::OPC_GOTO,  8'hFF, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd39, 2'd0);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd0,  2'd1);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd39, 2'd1);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd0,  2'd2);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd19, 2'd2);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd20, 2'd2);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd0,  2'd3);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd39, 2'd3);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd63, 2'd3);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd63, 2'd1);
    send_cmd(cnls_pkg::OPC_GOTO,  8'h00, 6'd63, 2'd0);
    send_cmd(cnls_pkg::OPC_PUT,   8'h80, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_PUT,   8'h7F, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_CLEAR, 8'h00, 6'd0,  2'd0);
    send_cmd(cnls_pkg::OPC_INIT,  8'h00, 6'd0,  2'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      sv = (ph_settle[p] < 0) ? $urandom_range(0, 255) : ph_settle[p];
      write_settle(8'(sv));
      rx_mode    = ph_rx[p];
      gap_max    = ph_gap[p];
      burst_left = 0;
      repeat (ph_items[p]) send_random();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("tb: %0d commands (init %0d, put %0d, clear %0d, goto %0d) under %0d settle times",
             n_cmd[0] + n_cmd[1] + n_cmd[2] + n_cmd[3], n_cmd[cnls_pkg::OPC_INIT],
             n_cmd[cnls_pkg::OPC_PUT], n_cmd[cnls_pkg::OPC_CLEAR], n_cmd[cnls_pkg::OPC_GOTO],
             n_settings);
    $display("tb: %0d pin changes compared, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
